// ===== rtl/core/sds_pkg.sv =====
// ----------------------------------------------------------------------------
// sds_pkg
// Shared widths, register codes and control types of the SMA deviation unit.
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int NUM_SYMBOLS = 16;
  localparam int WINDOW_MAX  = 32;

  localparam int SYMF_W     = 4;
  localparam int PRICE_W    = 32;
  localparam int TIME_W     = 64;
  localparam int SIG_W      = 17;
  localparam int WIN_W      = 6;
  localparam int MULT_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam int SYM_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int CUR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FILL_W  = $clog2(WINDOW_MAX + 1);
  localparam int DEPTH   = NUM_SYMBOLS * WINDOW_MAX;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TOT_W   = PRICE_W + $clog2(WINDOW_MAX);
  localparam int MAG_W   = PRICE_W + FILL_W;
  localparam int PROD_W  = MAG_W + MULT_W;
  localparam int Q_W     = 15;
  localparam int DIV_STEPS = Q_W;
  localparam int CNT_W   = $clog2(DIV_STEPS);

  localparam logic [WIN_W-1:0]  WIN_RESET  = WIN_W'(20);
  localparam logic [MULT_W-1:0] MULT_RESET = MULT_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW = 1'b0,
    REG_MULT   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              accept;
    logic              update;
    logic              mag;
    logic              mul;
    logic              cmp;
    logic              div_step;
    logic              load_out;
    logic              clr_en;
    logic [ADDR_W-1:0] clr_addr;
  } cmd_t;

  typedef struct packed {
    logic sym_ok;
    logic emit;
    logic early;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/sds_in_if.sv =====
// ----------------------------------------------------------------------------
// sds_in_if
// Tick channel: symbol index, price and timestamp with valid/ready.
// ----------------------------------------------------------------------------
interface sds_in_if import sds_pkg::*;;
  logic               valid;
  logic               ready;
  logic [SYMF_W-1:0]  symbol_index;
  logic [PRICE_W-1:0] price;
  logic [TIME_W-1:0]  timestamp;

  modport source (output valid, symbol_index, price, timestamp, input ready);
  modport sink   (input valid, symbol_index, price, timestamp, output ready);
endinterface

// ===== rtl/core/sds_out_if.sv =====
// ----------------------------------------------------------------------------
// sds_out_if
// Signal channel: symbol, deviation value, timestamp and zero-base flag.
// ----------------------------------------------------------------------------
interface sds_out_if import sds_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [SYMF_W-1:0]       out_symbol;
  logic signed [SIG_W-1:0] signal_value;
  logic [TIME_W-1:0]       out_time;
  logic                    zero_base;

  modport source (output valid, out_symbol, signal_value, out_time, zero_base, input ready);
  modport sink   (input valid, out_symbol, signal_value, out_time, zero_base, output ready);
endinterface

// ===== rtl/core/sds_datapath.sv =====
// ----------------------------------------------------------------------------
// sds_datapath
// Price ring memory, per-symbol cursor/fill/sum, deviation math and divider.
// ----------------------------------------------------------------------------
module sds_datapath import sds_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [SYMF_W-1:0]       in_symbol_index,
  input  logic [PRICE_W-1:0]      in_price,
  input  logic [TIME_W-1:0]       in_timestamp,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [SYMF_W-1:0]       out_symbol,
  output logic signed [SIG_W-1:0] out_signal_value,
  output logic [TIME_W-1:0]       out_time,
  output logic                    out_zero_base
);

  logic [WIN_W-1:0]  window_r;
  logic [MULT_W-1:0] mult_r;

  logic [PRICE_W-1:0] mem [DEPTH];
  logic [PRICE_W-1:0] rd_data_r;

  logic [CUR_W-1:0]  cursor_r [NUM_SYMBOLS];
  logic [FILL_W-1:0] fill_r   [NUM_SYMBOLS];
  logic [TOT_W-1:0]  total_r  [NUM_SYMBOLS];

  logic [SYMF_W-1:0]  symf_r;
  logic [SYM_W-1:0]   sym_r;
  logic [PRICE_W-1:0] price_r;
  logic [TIME_W-1:0]  time_r;
  logic [CUR_W-1:0]   cur_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [FILL_W-1:0]  w_r;

  logic [TOT_W-1:0]  sum_r;
  logic [MAG_W-1:0]  pw_r;
  logic [MAG_W-1:0]  mag_r;
  logic              neg_r;
  logic              zero_r;
  logic [PROD_W-1:0] prod_r;
  logic [TOT_W-1:0]  rem_r;
  logic [Q_W:0]      q_r;

  logic                    out_valid_r;
  logic [SYMF_W-1:0]       out_symbol_r;
  logic signed [SIG_W-1:0] out_value_r;
  logic [TIME_W-1:0]       out_time_r;
  logic                    out_zero_r;

  logic [FILL_W-1:0] w_eff;
  logic [SYM_W-1:0]  sym_idx;
  logic [CUR_W-1:0]  cur_in;
  logic [CUR_W-1:0]  cur_sel;
  logic [ADDR_W-1:0] rd_addr;
  logic [TOT_W-1:0]  tot_upd;
  logic [FILL_W-1:0] fill_old;
  logic [FILL_W-1:0] fill_upd;
  logic [FILL_W-1:0] cur_inc;
  logic [CUR_W-1:0]  cur_upd;
  logic              sat;
  logic [TOT_W:0]    rem_sh;
  logic [TOT_W:0]    sum_ext;
  logic              rem_ge;
  logic signed [SIG_W-1:0] q_ext;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WIN_RESET;
      mult_r   <= MULT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW: window_r <= cfg_data[WIN_W-1:0];
        REG_MULT:   mult_r   <= cfg_data[MULT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (window_r == '0) begin
      w_eff = FILL_W'(1);
    end else if (32'(window_r) > 32'(WINDOW_MAX)) begin
      w_eff = FILL_W'(WINDOW_MAX);
    end else begin
      w_eff = FILL_W'(window_r);
    end
  end

  assign sym_idx  = SYM_W'(in_symbol_index);
  assign cur_in   = cursor_r[sym_idx];
  assign cur_sel  = (FILL_W'(cur_in) >= w_eff) ? '0 : cur_in;
  assign rd_addr  = ADDR_W'(32'(sym_idx) * WINDOW_MAX + 32'(cur_sel));

  assign tot_upd  = total_r[sym_r] - TOT_W'(rd_data_r) + TOT_W'(price_r);
  assign fill_old = fill_r[sym_r];
  assign fill_upd = (fill_old < w_r) ? fill_old + FILL_W'(1) : fill_old;
  assign cur_inc  = FILL_W'(cur_r) + FILL_W'(1);
  assign cur_upd  = (cur_inc >= w_r) ? '0 : CUR_W'(cur_inc);

  assign sat      = prod_r >= PROD_W'(sum_r);
  assign rem_sh   = {rem_r, 1'b0};
  assign sum_ext  = {1'b0, sum_r};
  assign rem_ge   = rem_sh >= sum_ext;
  assign q_ext    = SIG_W'(q_r);

  assign sts.sym_ok   = 32'(in_symbol_index) < 32'(NUM_SYMBOLS);
  assign sts.emit     = fill_upd >= w_r;
  assign sts.early    = zero_r || sat;
  assign sts.out_free = !out_valid_r || out_ready;

  // Price ring memory
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[cmd.clr_addr] <= '0;
    end else if (cmd.update) begin
      mem[addr_r] <= price_r;
    end
    if (cmd.accept) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Per-symbol state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SYMBOLS; i++) begin
        cursor_r[i] <= '0;
        fill_r[i]   <= '0;
        total_r[i]  <= '0;
      end
    end else if (cmd.update) begin
      cursor_r[sym_r] <= cur_upd;
      fill_r[sym_r]   <= fill_upd;
      total_r[sym_r]  <= tot_upd;
    end
  end

  // Item and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      symf_r  <= in_symbol_index;
      sym_r   <= sym_idx;
      price_r <= in_price;
      time_r  <= in_timestamp;
      cur_r   <= cur_sel;
      addr_r  <= rd_addr;
      w_r     <= w_eff;
    end
    if (cmd.update) begin
      sum_r <= tot_upd;
      pw_r  <= MAG_W'(price_r) * MAG_W'(w_r);
    end
    if (cmd.mag) begin
      zero_r <= (sum_r == '0);
      if (pw_r >= MAG_W'(sum_r)) begin
        mag_r <= pw_r - MAG_W'(sum_r);
        neg_r <= 1'b0;
      end else begin
        mag_r <= MAG_W'(sum_r) - pw_r;
        neg_r <= 1'b1;
      end
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(mag_r) * PROD_W'(mult_r);
    end
    if (cmd.cmp) begin
      rem_r <= prod_r[TOT_W-1:0];
      if (zero_r) begin
        q_r <= '0;
      end else if (sat) begin
        q_r <= {1'b1, {Q_W{1'b0}}};
      end else begin
        q_r <= '0;
      end
    end
    if (cmd.div_step) begin
      if (rem_ge) begin
        rem_r <= TOT_W'(rem_sh - sum_ext);
        q_r   <= {q_r[Q_W-1:0], 1'b1};
      end else begin
        rem_r <= rem_sh[TOT_W-1:0];
        q_r   <= {q_r[Q_W-1:0], 1'b0};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_symbol_r <= symf_r;
      out_value_r  <= neg_r ? -q_ext : q_ext;
      out_time_r   <= time_r;
      out_zero_r   <= zero_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = out_symbol_r;
  assign out_signal_value = out_value_r;
  assign out_time         = out_time_r;
  assign out_zero_base    = out_zero_r;

endmodule

// ===== rtl/core/sds_ctrl.sv =====
// ----------------------------------------------------------------------------
// sds_ctrl
// Sequencer: memory clear after reset, tick update, math steps, divide loop.
// ----------------------------------------------------------------------------
module sds_ctrl import sds_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_UPD,
    S_MAG,
    S_MUL,
    S_CMP,
    S_DIV,
    S_OUT
  } state_t;

  state_t            state_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [CNT_W-1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_addr_r <= '0;
      cnt_r      <= '0;
    end else begin
      unique case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && sts.sym_ok) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          state_r <= sts.emit ? S_MAG : S_IDLE;
        end
        S_MAG: state_r <= S_MUL;
        S_MUL: state_r <= S_CMP;
        S_CMP: begin
          cnt_r   <= '0;
          state_r <= sts.early ? S_OUT : S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (sts.out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.clr_addr = clr_addr_r;
    cmd.clr_en   = (state_r == S_CLR);
    cmd.accept   = (state_r == S_IDLE) && in_valid && sts.sym_ok;
    cmd.update   = (state_r == S_UPD);
    cmd.mag      = (state_r == S_MAG);
    cmd.mul      = (state_r == S_MUL);
    cmd.cmp      = (state_r == S_CMP);
    cmd.div_step = (state_r == S_DIV);
    cmd.load_out = (state_r == S_OUT) && sts.out_free;
  end

endmodule

// ===== rtl/core/sma_deviation_signal_unit.sv =====
// ----------------------------------------------------------------------------
// sma_deviation_signal_unit
// Per-symbol moving-average deviation signal, (price*W - sum)*gain/sum, Q2.15.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   symbol_index, price, timestamp
//  out_ch   out  valid/ready   out_symbol, signal_value, out_time, zero_base
//  cfg_*    in   write enable  cfg_index (0 window length, 1 gain), cfg_data
//
// A tick that leaves the ring filling passes only the accept and ring update steps.
// Emitting ticks add magnitude, multiply, compare, 15-step restoring divide.
// Zero-sum and saturated results skip the divider.
// After reset a clearing pass zeroes the price memory; in_ch.ready stays low.
// A waiting result sits in the output register while the next tick is taken.
// ----------------------------------------------------------------------------
module sma_deviation_signal_unit import sds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sds_in_if.sink                in_ch,
  sds_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  sds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sds_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_symbol_index  (in_ch.symbol_index),
    .in_price         (in_ch.price),
    .in_timestamp     (in_ch.timestamp),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_symbol       (out_ch.out_symbol),
    .out_signal_value (out_ch.signal_value),
    .out_time         (out_ch.out_time),
    .out_zero_base    (out_ch.zero_base)
  );

endmodule

// ===== verif/sds_deviation_checker.sv =====
// ----------------------------------------------------------------------------
// sds_deviation_checker
// Watches the tick and signal channels and the register port, keeps its own
// per-symbol price rings and running sums, predicts each deviation signal and
// compares every signal item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sds_deviation_checker import sds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sds_in_if                     in_mon,
  sds_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [SYMF_W-1:0]       sym;
    logic signed [SIG_W-1:0] value;
    logic [TIME_W-1:0]       stamp;
    logic                    zero;
  } deviation_t;

  logic [WIN_W-1:0]   win_reg;
  logic [MULT_W-1:0]  mult_reg;
  logic [PRICE_W-1:0] ring [DEPTH];
  logic [CUR_W-1:0]   cursor [NUM_SYMBOLS];
  logic [FILL_W-1:0]  fill [NUM_SYMBOLS];
  logic [TOT_W-1:0]   total [NUM_SYMBOLS];
  deviation_t         deviation_q [$];

  function automatic bit next_deviation(input logic [SYMF_W-1:0] sym,
                                        input logic [PRICE_W-1:0] price,
                                        input logic [TIME_W-1:0] stamp,
                                        output deviation_t res);
    int unsigned w;
    int unsigned cur;
    int unsigned slot;
    logic [63:0] sum;
    logic [63:0] pw;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] q;
    bit          neg;
    bit          zero;
    w = (win_reg == 0) ? 1 : (win_reg > WINDOW_MAX) ? WINDOW_MAX : win_reg;
    cur = cursor[sym];
    if (cur >= w) cur = 0;
    slot = sym * WINDOW_MAX + cur;
    total[sym] = total[sym] - ring[slot] + price;
    ring[slot] = price;
    cur++;
    if (cur >= w) cur = 0;
    cursor[sym] = CUR_W'(cur);
    if (fill[sym] < w) fill[sym]++;
    res = '0;
    if (fill[sym] < w) return 1'b0;
    sum  = 64'(total[sym]);
    q    = '0;
    neg  = 1'b0;
    zero = 1'b0;
    if (sum == 0) begin
      zero = 1'b1;
    end else begin
      pw = 64'(price) * 64'(w);
      if (pw >= sum) begin
        mag = pw - sum;
      end else begin
        mag = sum - pw;
        neg = 1'b1;
      end
      prod = mag * 64'(mult_reg);
      if (prod >= sum) q = 64'd32768;
      else q = (prod << 15) / sum;
    end
    res.sym   = sym;
    res.value = SIG_W'(neg ? (64'd0 - q) : q);
    res.stamp = stamp;
    res.zero  = zero;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    deviation_t got;
    deviation_t want;
    if (!rst_n) begin
      win_reg  = WIN_RESET;
      mult_reg = MULT_RESET;
      for (int i = 0; i < DEPTH; i++) ring[i] = '0;
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
        cursor[s] = '0;
        fill[s]   = '0;
        total[s]  = '0;
      end
      deviation_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WINDOW) win_reg = cfg_data[WIN_W-1:0];
        else if (cfg_index == REG_MULT) mult_reg = cfg_data[MULT_W-1:0];
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.out_symbol, out_mon.signal_value, out_mon.out_time,
                out_mon.zero_base};
        if (deviation_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected signal: sym %0d value %0d time %h zero %0b",
                     got.sym, got.value, got.stamp, got.zero);
        end else begin
          want = deviation_q.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp sym %0d value %0d time %h zero %0b / got sym %0d value %0d time %h zero %0b",
                       want.sym, want.value, want.stamp, want.zero,
                       got.sym, got.value, got.stamp, got.zero);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (next_deviation(in_mon.symbol_index, in_mon.price, in_mon.timestamp, want))
          deviation_q.push_back(want);
      end
    end
    pending = deviation_q.size();
  end

endmodule

// ===== verif/tb_sma_deviation_signal_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sma_deviation_signal_unit
// Drives price ticks and register writes into the SMA deviation unit with
// random idling on both channels; a checker beside the block predicts and
// compares each signal item. Directed corner ticks first, then random phases
// over several window and gain settings.
// ----------------------------------------------------------------------------
module tb_sma_deviation_signal_unit;
  import sds_pkg::*;

  localparam int PHASES       = 5;
  localparam int SETTLE_CYCLES = 32;
  localparam int STALL_LIMIT  = 4000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    stall_cycles;
  bit                    steady;
  logic [PRICE_W-1:0]    base_px [NUM_SYMBOLS];

  int unsigned ph_win   [PHASES] = '{63, 20, 5, 1, 32};
  int unsigned ph_mult  [PHASES] = '{65535, 1000, 0, 1, 40000};
  int unsigned ph_items [PHASES] = '{170, 150, 170, 60, 130};
  int unsigned ph_syms  [PHASES] = '{3, 4, 16, 16, 2};

  sds_in_if  in_ch ();
  sds_out_if out_ch ();

  sma_deviation_signal_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sds_deviation_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 8);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_tick(input logic [SYMF_W-1:0] sym, input logic [PRICE_W-1:0] px,
                           input logic [TIME_W-1:0] ts);
    while (!steady && $urandom_range(0, 99) < 8) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.symbol_index <= sym;
    in_ch.price        <= px;
    in_ch.timestamp    <= ts;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // hold ticks back until every predicted signal is out and the block is idle
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] win,
                            input logic [CFG_DATA_W-1:0] mult);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW;
    cfg_data  <= win;
    @(negedge clk);
    cfg_index <= REG_MULT;
    cfg_data  <= mult;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [SYMF_W-1:0]  sym;
    logic [PRICE_W-1:0] px;
    int unsigned        r;
    int unsigned        mult;
    rst_n              = 1'b0;
    steady             = 1'b0;
    stall_cycles       = 0;
    cfg_we             = 1'b0;
    cfg_index          = REG_WINDOW;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.symbol_index = '0;
    in_ch.price        = '0;
    in_ch.timestamp    = '0;
    out_ch.ready       = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // window of two, unit gain: zero sum, both saturations, exact divides
    set_config(16'd2, 16'd1);
    send_tick(4'd0, 32'h0, 64'h0);
    send_tick(4'd0, 32'h0, '1);
    send_tick(4'd0, '1, 64'h5555_5555_5555_5555);
    send_tick(4'd0, 32'h0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_tick(4'd15, 32'd100, {$urandom, $urandom});
    send_tick(4'd15, 32'd101, {$urandom, $urandom});
    send_tick(4'd15, 32'd99, {$urandom, $urandom});
    send_tick(4'd5, '1, {$urandom, $urandom});
    send_tick(4'd5, '1, {$urandom, $urandom});
    send_tick(4'd10, 32'hAAAA_AAAA, {$urandom, $urandom});
    send_tick(4'd10, 32'h5555_5555, {$urandom, $urandom});
    settle();
    set_config(16'd2, 16'hFFFF);
    send_tick(4'd3, 32'h1000_0000, {$urandom, $urandom});
    send_tick(4'd3, 32'h1000_0001, {$urandom, $urandom});
    // window register zero acts as one, zero gain
    settle();
    set_config(16'd0, 16'd0);
    send_tick(4'd7, 32'd12345, {$urandom, $urandom});
    send_tick(4'd7, 32'h0, {$urandom, $urandom});
    send_tick(4'd0, 32'h5555_5555, {$urandom, $urandom});

    // random phases; window changes without reset carry old ring contents
    for (int p = 0; p < PHASES; p++) begin
      settle();
      mult = (p == 2) ? $urandom_range(2, 65534) : ph_mult[p];
      set_config(CFG_DATA_W'(ph_win[p]), CFG_DATA_W'(mult));
      for (int s = 0; s < NUM_SYMBOLS; s++)
        base_px[s] = $urandom_range(32'h0100_0000, 32'hF000_0000);
      steady = (p == PHASES - 1);
      for (int i = 0; i < ph_items[p]; i++) begin
        if (p == 1 && i == ph_items[p] / 2) settle();
        if ($urandom_range(0, 9) == 0) sym = SYMF_W'($urandom_range(0, 15));
        else sym = SYMF_W'($urandom_range(0, ph_syms[p] - 1));
        r = $urandom_range(0, 99);
        if (r < 70) px = base_px[sym] + ($urandom & ((32'd1 << $urandom_range(0, 20)) - 1));
        else if (r < 82) px = $urandom;
        else if (r < 90) px = '0;
        else if (r < 95) px = '1;
        else px = base_px[sym];
        send_tick(sym, px, {$urandom, $urandom});
      end
    end
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sds_pkg.sv
rtl/core/sds_in_if.sv
rtl/core/sds_out_if.sv
rtl/core/sds_datapath.sv
rtl/core/sds_ctrl.sv
rtl/core/sma_deviation_signal_unit.sv
verif/sds_deviation_checker.sv
verif/tb_sma_deviation_signal_unit.sv
